/* hw/rtl/elf_header_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// ELF header parser assertion macros
// Shared concurrent assertion helpers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ELF_HEADER_PARSER_TOP_DEFINES_SVH
`define ELF_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define EHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define EHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EHP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define EHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/ehp_pkg.sv */
// ----------------------------------------------------------------------------
// ehp_pkg
// Types, codes and tables shared by the ELF header parser modules.
// ----------------------------------------------------------------------------
package ehp_pkg;

   localparam int IDENT_LEN   = 16;
   localparam int HDR_FIELDS  = 13;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [4:0] HDR_ID_BASE = 5'd16;

   typedef enum logic [1:0] {
      OP_DATA    = 2'd0,
      OP_END     = 2'd1,
      OP_RESTART = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EARLY_END = 2'd1,
      ST_BAD_MAGIC = 2'd2
   } status_type;

   // classified command held in the queue
   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
   } cmd_type;

   function automatic logic [7:0] magic_byte(logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = 8'h7F;
         2'd1:    m = 8'h45;
         2'd2:    m = 8'h4C;
         default: m = 8'h46;
      endcase
      return m;
   endfunction

   // header field width in bytes; wide selects the 64-bit layout
   function automatic logic [3:0] field_size(logic [3:0] fc, logic wide);
      logic [3:0] s;
      case (fc)
         4'd2, 4'd6:        s = 4'd4;
         4'd3, 4'd4, 4'd5:  s = wide ? 4'd8 : 4'd4;
         default:           s = 4'd2;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/elf_header_parser_top.sv */
// ----------------------------------------------------------------------------
// elf_header_parser_top
// Byte-stream ELF file header parser with decoupled intake and parse stages.
// ----------------------------------------------------------------------------
// The block takes an ELF file one byte per request transaction and returns one
// response transaction per identification byte (field ids 0..15) and per
// assembled header field (ids 16..28, file type through section name string
// index), zero extended to 64 bits. Class 1/2 picks the 32/64-bit layout of
// entry, phoff and shoff; data encoding 1/2 picks little/big-endian assembly,
// any other encoding yields zero values. Bad magic ends the header on ident
// byte 15 with status 2; an unknown class ends it there with status 0. An
// end-of-input op before the header completes returns status 1 for the
// pending field. A restart op clears the parse state and returns nothing;
// op 3 is dropped.
// Throughput is one byte per clock while responses are taken: the parse
// stage updates a 64-bit accumulator and small counters once per command,
// and its result lands in an output register. A request goes through the
// command queue of QUEUE_DEPTH entries between intake and parse, then the
// parse stage; that stage keeps consuming while a response waits only if
// that response is being taken in the same cycle.
// ----------------------------------------------------------------------------
module elf_header_parser_top #(
   parameter int QUEUE_DEPTH = ehp_pkg::QUEUE_DEPTH  // two or more entries
) (
   input  logic        clock,
   input  logic        reset,
   // request channel: one op and byte per transaction
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_in_byte,
   // response channel: one field per transaction
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_field_id,
   output logic [63:0] rsp_field_value,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   // classified commands between intake and parse
   logic             cmd_valid;
   logic             cmd_ready;
   ehp_pkg::cmd_type cmd;

   // intake: op decode and command queue
   ehp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_in_byte (req_in_byte),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // parse: ident checks, field assembly, response register
   ehp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_id    (rsp_field_id),
      .rsp_field_value (rsp_field_value),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

/* hw/rtl/ehp_front.sv */
// ----------------------------------------------------------------------------
// ehp_front
// Accepts request transactions, classifies the op and queues commands.
// ----------------------------------------------------------------------------
`include "elf_header_parser_top_defines.svh"

module ehp_front #(
   parameter int DEPTH = ehp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_in_byte,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output ehp_pkg::cmd_type cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ehp_pkg::cmd_type  q_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;
   ehp_pkg::cmd_type  new_cmd;

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign pop       = cmd_valid && cmd_ready;

   // unused op code is dropped here: no state change, no result
   assign push = req_valid && req_ready &&
                 (ehp_pkg::op_type'(req_op) != ehp_pkg::OP_UNUSED);

   assign new_cmd.op   = ehp_pkg::op_type'(req_op);
   assign new_cmd.data = req_in_byte;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `EHP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `EHP_ASSERT_NEXT(a_push_visible, clock, reset, push && !pop, cmd_valid)
   `EHP_ASSERT_IMPL(a_ready_has_room, clock, reset, req_ready, count_ff < CNT_W'(DEPTH))

endmodule

/* hw/rtl/ehp_back.sv */
// ----------------------------------------------------------------------------
// ehp_back
// Header parse state and result register; one command per cycle unless a response is held.
// ----------------------------------------------------------------------------
`include "elf_header_parser_top_defines.svh"

module ehp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ehp_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [4:0]       rsp_field_id,
   output logic [63:0]      rsp_field_value,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);

   logic [4:0]  pos_ff, pos_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  fc_ff, fc_in;
   logic [2:0]  bif_ff, bif_in;
   logic        magic_ok_ff, magic_ok_in;
   logic        cls32_ff, cls32_in;
   logic        cls64_ff, cls64_in;
   logic        enc_le_ff, enc_le_in;
   logic        enc_be_ff, enc_be_in;
   logic        finished_ff, finished_in;

   logic        rsp_valid_ff;
   logic [4:0]  id_ff;
   logic [63:0] value_ff;
   logic [1:0]  status_ff;
   logic        last_ff;

   logic                 pop;
   logic                 emit;
   logic [4:0]           e_id;
   logic [63:0]          e_val;
   ehp_pkg::status_type  e_st;
   logic                 e_last;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      logic [3:0]  fc_c;
      logic [3:0]  size;
      logic [63:0] acc_nx;
      logic [63:0] byte_ext;

      pos_in      = pos_ff;
      acc_in      = acc_ff;
      fc_in       = fc_ff;
      bif_in      = bif_ff;
      magic_ok_in = magic_ok_ff;
      cls32_in    = cls32_ff;
      cls64_in    = cls64_ff;
      enc_le_in   = enc_le_ff;
      enc_be_in   = enc_be_ff;
      finished_in = finished_ff;
      emit        = 1'b0;
      e_id        = pos_ff;
      e_val       = '0;
      e_st        = ehp_pkg::ST_OK;
      e_last      = 1'b0;

      fc_c     = (fc_ff < 4'(ehp_pkg::HDR_FIELDS)) ? fc_ff : 4'(ehp_pkg::HDR_FIELDS - 1);
      size     = ehp_pkg::field_size(fc_c, cls64_ff);
      byte_ext = {56'd0, cmd.data};
      if (enc_le_ff) begin
         acc_nx = acc_ff | (byte_ext << {bif_ff, 3'b000});
      end else if (enc_be_ff) begin
         acc_nx = {acc_ff[55:0], cmd.data};
      end else begin
         acc_nx = acc_ff;
      end

      if (pop) begin
         case (cmd.op)
            ehp_pkg::OP_RESTART: begin
               pos_in      = '0;
               acc_in      = '0;
               fc_in       = '0;
               bif_in      = '0;
               magic_ok_in = 1'b1;
               cls32_in    = 1'b0;
               cls64_in    = 1'b0;
               enc_le_in   = 1'b0;
               enc_be_in   = 1'b0;
               finished_in = 1'b0;
            end
            ehp_pkg::OP_END: begin
               if (!finished_ff) begin
                  emit        = 1'b1;
                  e_id        = (pos_ff < 5'(ehp_pkg::IDENT_LEN)) ?
                                pos_ff : ehp_pkg::HDR_ID_BASE + {1'b0, fc_c};
                  e_st        = ehp_pkg::ST_EARLY_END;
                  e_last      = 1'b1;
                  finished_in = 1'b1;
               end
            end
            ehp_pkg::OP_DATA: begin
               if (!finished_ff) begin
                  if (pos_ff < 5'(ehp_pkg::IDENT_LEN)) begin
                     emit   = 1'b1;
                     e_id   = pos_ff;
                     e_val  = byte_ext;
                     pos_in = pos_ff + 1'b1;
                     if (pos_ff < 5'd4 && cmd.data != ehp_pkg::magic_byte(pos_ff[1:0])) begin
                        magic_ok_in = 1'b0;
                     end
                     if (pos_ff == 5'd4) begin
                        cls32_in = (cmd.data == 8'd1);
                        cls64_in = (cmd.data == 8'd2);
                     end
                     if (pos_ff == 5'd5) begin
                        enc_le_in = (cmd.data == 8'd1);
                        enc_be_in = (cmd.data == 8'd2);
                     end
                     if (pos_ff == 5'(ehp_pkg::IDENT_LEN - 1)) begin
                        if (!magic_ok_ff) begin
                           e_st        = ehp_pkg::ST_BAD_MAGIC;
                           e_last      = 1'b1;
                           finished_in = 1'b1;
                        end else if (!(cls32_ff || cls64_ff)) begin
                           e_last      = 1'b1;
                           finished_in = 1'b1;
                        end
                     end
                  end else if (({1'b0, bif_ff} + 4'd1) >= size) begin
                     emit   = 1'b1;
                     e_id   = ehp_pkg::HDR_ID_BASE + {1'b0, fc_c};
                     e_val  = acc_nx;
                     e_last = (fc_c == 4'(ehp_pkg::HDR_FIELDS - 1));
                     acc_in = '0;
                     bif_in = '0;
                     fc_in  = fc_c + 1'b1;
                     if (e_last) begin
                        finished_in = 1'b1;
                     end
                  end else begin
                     acc_in = acc_nx;
                     bif_in = bif_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         acc_ff       <= '0;
         fc_ff        <= '0;
         bif_ff       <= '0;
         magic_ok_ff  <= 1'b1;
         cls32_ff     <= 1'b0;
         cls64_ff     <= 1'b0;
         enc_le_ff    <= 1'b0;
         enc_be_ff    <= 1'b0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         fc_ff        <= fc_in;
         bif_ff       <= bif_in;
         magic_ok_ff  <= magic_ok_in;
         cls32_ff     <= cls32_in;
         cls64_ff     <= cls64_in;
         enc_le_ff    <= enc_le_in;
         enc_be_ff    <= enc_be_in;
         finished_ff  <= finished_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded only with a new result
   always_ff @(posedge clock) begin
      if (emit) begin
         id_ff     <= e_id;
         value_ff  <= e_val;
         status_ff <= e_st;
         last_ff   <= e_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_id    = id_ff;
   assign rsp_field_value = value_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

   `EHP_ASSERT_IMPL(a_err_is_last, clock, reset,
      rsp_valid_ff && status_ff != ehp_pkg::ST_OK, last_ff)
   `EHP_ASSERT_IMPL(a_quiet_when_done, clock, reset,
      pop && finished_ff, !emit)
   `EHP_ASSERT_IMPL(a_pos_bound, clock, reset, 1'b1, pos_ff <= 5'(ehp_pkg::IDENT_LEN))
   `EHP_ASSERT_IMPL(a_fc_bound, clock, reset, 1'b1, fc_ff <= 4'(ehp_pkg::HDR_FIELDS))

endmodule
